[rtl/async_byte_sync_deframer_assert.svh]
// Assertion macros for the byte synchronizer and deframer.
`ifndef ASYNC_BYTE_SYNC_DEFRAMER_ASSERT_SVH
`define ASYNC_BYTE_SYNC_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define ABSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

[rtl/absd_pkg.sv]
// Shared types and constants of the byte synchronizer and deframer.
package absd_pkg;

    localparam int SCORE_W = 16;
    localparam int DIFF_W  = 17;
    localparam int LEAK_SHIFT = 4;

    localparam logic signed [DIFF_W-1:0] SCORE_LIMIT = 17'sd32767;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;
    localparam logic [7:0] SYNC_RESET = 8'h2A;
    localparam logic [4:0] HDR_RESET  = 5'd5;
    localparam logic [7:0] FLEN_RESET = 8'd240;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN  = 2'd2;

    typedef logic signed [SCORE_W-1:0] t_score;

    typedef struct packed {
        logic [7:0] pos;
        logic       adv;
        logic       fend;
    } t_frm_res;

endpackage

[rtl/absd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module absd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

[rtl/absd_score_store.sv]
// Phase score memory with per-entry valid bits so unwritten scores read as zero.
module absd_score_store import absd_pkg::*; #(
    parameter int BIT_PHASES = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(BIT_PHASES)-1:0] i_rd_addr,
    output t_score                        o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(BIT_PHASES)-1:0] i_wr_addr,
    input  t_score                        i_wr_data
);

    logic [BIT_PHASES-1:0] r_valid;
    logic                  r_rd_vld;
    logic [SCORE_W-1:0]    s_q;

    absd_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (BIT_PHASES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (s_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? t_score'(s_q) : t_score'(0);

endmodule

[rtl/absd_framer.sv]
// Frame position counter with header sync check and frame wrap.
module absd_framer import absd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_store,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_sync_byte,
    input  logic [4:0] i_header_len,
    input  logic [7:0] i_frame_len,
    output t_frm_res o_res
);

    logic [7:0] r_pos;
    logic [7:0] n_pos;
    logic [8:0] s_next;
    logic       s_adv;
    logic       s_end;

    assign s_adv  = (r_pos >= {3'b000, i_header_len}) || (i_byte == i_sync_byte);
    assign s_next = s_adv ? ({1'b0, r_pos} + 9'd1) : 9'd0;
    assign s_end  = (s_next >= {1'b0, i_frame_len});
    assign n_pos  = s_end ? 8'd0 : s_next[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
        end else if (i_store) begin
            r_pos <= n_pos;
        end
    end

    assign o_res.pos  = r_pos;
    assign o_res.adv  = s_adv;
    assign o_res.fend = s_end;

endmodule

[rtl/async_byte_sync_deframer.sv]
// Top level: soft-decision bit synchronizer with phase score memory and deframer.
//
//  Channel  Dir  Handshake                 Content
//  s        in   i_s_tvalid / o_s_tready   raw radio FIFO byte
//  m        out  o_m_tvalid / i_m_tready   recovered byte, position, flags
//  cfg      in   i_cfg_valid / o_cfg_ready register index and write data
//
// Every sample scans all phase scores through the single read port of the
// score memory, then writes back one score. Reset is synchronous; no clearing
// pass is needed. A stalled result output holds the block whenever a result
// has to move into the full output register, either at a further result of
// the item or at the end of the item.
`include "async_byte_sync_deframer_assert.svh"

module async_byte_sync_deframer import absd_pkg::*; #(
    parameter int BIT_PHASES        = 10,
    parameter int SAMPLES_PER_INPUT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] raw_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // [7:0] byte_value, [15:8] frame_pos
    output logic                 o_m_tlast,
    output logic [2:0]           o_m_tuser,   // [0] accepted, [1] inverted, [2] frame_end
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int PW = $clog2(BIT_PHASES);
    localparam int SW = $clog2(SAMPLES_PER_INPUT + 1);
    localparam logic [PW-1:0] LAST_PH  = PW'(BIT_PHASES - 1);
    localparam logic [SW-1:0] LAST_SMP = SW'(SAMPLES_PER_INPUT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMPLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state r_state;

    logic [7:0]  r_sync;
    logic [4:0]  r_hlen;
    logic [7:0]  r_flen;

    logic [7:0]  r_raw;
    logic [8:0]  r_shift;
    logic        r_d;
    logic [SW-1:0] r_smp;
    logic [PW-1:0] r_ph;
    logic [PW-1:0] r_k;
    t_score      r_prev;
    t_score      r_first;
    t_score      r_cur;
    logic signed [DIFF_W-1:0] r_best;
    logic [PW-1:0] r_bestk;
    logic        r_emit;
    logic        r_inv;

    logic        r_pend_valid;
    logic [7:0]  r_pend_byte;
    logic        r_pend_inv;
    t_frm_res    r_pend_res;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_inv;
    logic        r_out_last;
    t_frm_res    r_out_res;

    logic        s_rd_en;
    logic [PW-1:0] s_rd_addr;
    t_score      s_rd_data;
    t_score      s_ev_b;
    logic signed [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0] s_diff_abs;
    logic [DIFF_W-1:0] s_best_abs;
    logic [PW-1:0] s_ev_idx;
    logic        s_ev_take;
    logic signed [DIFF_W-1:0] n_best;
    logic [PW-1:0] n_bestk;
    logic signed [DIFF_W-1:0] s_cur17;
    logic signed [DIFF_W-1:0] n_score17;
    t_score      n_score;
    logic        s_out_free;
    logic        s_commit;
    logic        s_push;
    logic        s_push_last;
    logic [7:0]  n_byte;
    t_frm_res    s_frm;

    assign s_rd_en   = (r_state == S_SAMPLE) || ((r_state == S_SCAN) && (r_k != LAST_PH));
    assign s_rd_addr = (r_state == S_SAMPLE) ? '0 : r_k + 1'b1;

    absd_score_store #(
        .BIT_PHASES (BIT_PHASES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data),
        .i_wr_en   (r_state == S_DECIDE),
        .i_wr_addr (r_ph),
        .i_wr_data (n_score)
    );

    always_comb begin
        s_ev_b     = (r_state == S_DECIDE) ? r_first : s_rd_data;
        n_diff     = DIFF_W'(r_prev) - DIFF_W'(s_ev_b);
        s_diff_abs = n_diff[DIFF_W-1] ? DIFF_W'(-n_diff) : DIFF_W'(n_diff);
        s_best_abs = r_best[DIFF_W-1] ? DIFF_W'(-r_best) : DIFF_W'(r_best);
        s_ev_idx   = (r_state == S_DECIDE) ? LAST_PH : r_k - 1'b1;
        s_ev_take  = (((r_state == S_SCAN) && (r_k != '0)) || (r_state == S_DECIDE))
                     && (s_diff_abs > s_best_abs);
        n_best     = s_ev_take ? n_diff : r_best;
        n_bestk    = s_ev_take ? s_ev_idx : r_bestk;
    end

    always_comb begin
        s_cur17 = DIFF_W'(r_cur);
        if (r_d) begin
            n_score17 = s_cur17 + ((SCORE_LIMIT - s_cur17) >>> LEAK_SHIFT);
        end else begin
            n_score17 = s_cur17 - ((SCORE_LIMIT + s_cur17) >>> LEAK_SHIFT);
        end
        n_score = t_score'(n_score17[SCORE_W-1:0]);
    end

    assign s_out_free  = !r_out_valid || i_m_tready;
    assign s_commit    = (r_state == S_EMIT) && r_emit && (!r_pend_valid || s_out_free);
    assign s_push_last = (r_state == S_FLUSH) && r_pend_valid && s_out_free;
    assign s_push      = (s_commit && r_pend_valid) || s_push_last;
    assign n_byte      = r_shift[7:0] ^ (r_inv ? BYTE_MASK : 8'h00);

    absd_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_store      (s_commit),
        .i_byte       (n_byte),
        .i_sync_byte  (r_sync),
        .i_header_len (r_hlen),
        .i_frame_len  (r_flen),
        .o_res        (s_frm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sync       <= SYNC_RESET;
            r_hlen       <= HDR_RESET;
            r_flen       <= FLEN_RESET;
            r_shift      <= '0;
            r_ph         <= '0;
            r_k          <= '0;
            r_smp        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SYNC_BYTE:  r_sync <= i_cfg_data;
                    CFG_HEADER_LEN: r_hlen <= i_cfg_data[4:0];
                    CFG_FRAME_LEN:  r_flen <= i_cfg_data;
                    default: ;
                endcase
            end

            if (s_push) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_pend_byte;
                r_out_inv   <= r_pend_inv;
                r_out_res   <= r_pend_res;
                r_out_last  <= s_push_last;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_raw   <= i_s_tdata;
                        r_smp   <= '0;
                        r_state <= S_SAMPLE;
                    end
                end
                S_SAMPLE: begin
                    r_d     <= r_raw[7];
                    r_shift <= {r_raw[7], r_shift[8:1]};
                    r_raw   <= {r_raw[5:0], 2'b00};
                    r_best  <= '0;
                    r_bestk <= '0;
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_k == '0) begin
                        r_first <= s_rd_data;
                    end
                    if (r_k == r_ph) begin
                        r_cur <= s_rd_data;
                    end
                    r_prev  <= s_rd_data;
                    r_best  <= n_best;
                    r_bestk <= n_bestk;
                    if (r_k == LAST_PH) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_emit  <= (r_ph == n_bestk);
                    r_inv   <= n_best[DIFF_W-1];
                    r_ph    <= (r_ph == LAST_PH) ? '0 : r_ph + 1'b1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_emit || s_commit) begin
                        if (s_commit) begin
                            r_pend_valid <= 1'b1;
                            r_pend_byte  <= n_byte;
                            r_pend_inv   <= r_inv;
                            r_pend_res   <= s_frm;
                            r_shift[7:0] <= n_byte;
                        end
                        if (r_smp == LAST_SMP) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_smp   <= r_smp + 1'b1;
                            r_state <= S_SAMPLE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (s_out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_res.pos, r_out_byte};
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = {r_out_res.fend, r_out_inv, r_out_res.adv};

    `ABSD_ASSERT_NOW(a_idle_no_pending, o_s_tready, !r_pend_valid)
    `ABSD_ASSERT_NEXT(a_flush_sets_last, s_push_last, o_m_tvalid && o_m_tlast)
    `ABSD_ASSERT_NOW(a_pos_in_range, o_m_tvalid, o_m_tdata[15:8] != 8'hFF)

endmodule

[tb/async_byte_sync_deframer_checker.sv]
// Checker for the byte synchronizer and deframer: predicts recovered bytes and compares results.
`timescale 1ns / 100ps

module async_byte_sync_deframer_checker import absd_pkg::*; #(
    parameter int BIT_PHASES        = 10,
    parameter int SAMPLES_PER_INPUT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] raw_byte
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [15:0]          i_m_tdata,   // [7:0] byte_value, [15:8] frame_pos
    input  logic                 i_m_tlast,
    input  logic [2:0]           i_m_tuser,   // [0] accepted, [1] inverted, [2] frame_end
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_items,
    output int                   o_results,
    output int                   o_frame_ends,
    output int                   o_inverted,
    output int                   o_rejected
);

    typedef struct packed {
        logic [7:0] byte_value;
        logic [7:0] frame_pos;
        logic       accepted;
        logic       inverted;
        logic       frame_end;
        logic       last_of_run;
    } t_rx_byte;

    t_rx_byte   expected_bytes[$];

    int         score_by_phase[BIT_PHASES];
    int         line_phase;
    logic [8:0] bit_window;
    logic [7:0] frame_pos_now;

    logic [7:0] cfg_sync;
    logic [4:0] cfg_hdr;
    logic [7:0] cfg_flen;

    function automatic void recover_bytes(input logic [7:0] raw);
        logic [7:0] rest;
        logic       sample;
        int         best;
        int         diff;
        int         peak_phase;
        int         sc;
        int         next_pos;
        int         first_new;
        t_rx_byte   rb;
        rest = raw;
        first_new = expected_bytes.size();
        for (int s = 0; s < SAMPLES_PER_INPUT; s++) begin
            sample = rest[7];
            rest = rest << 2;
            bit_window = {sample, bit_window[8:1]};
            best = 0;
            peak_phase = 0;
            for (int k = 0; k < BIT_PHASES; k++) begin
                diff = score_by_phase[k] - score_by_phase[(k + 1) % BIT_PHASES];
                if (((diff < 0) ? -diff : diff) > ((best < 0) ? -best : best)) begin
                    best = diff;
                    peak_phase = k;
                end
            end
            if (line_phase == peak_phase) begin
                if (best < 0) begin
                    bit_window[7:0] = ~bit_window[7:0];
                end
                rb.byte_value = bit_window[7:0];
                rb.inverted = (best < 0);
                rb.last_of_run = 1'b0;
                rb.frame_pos = frame_pos_now;
                rb.accepted = (frame_pos_now >= cfg_hdr) || (bit_window[7:0] == cfg_sync);
                next_pos = rb.accepted ? int'(frame_pos_now) + 1 : 0;
                rb.frame_end = (next_pos >= int'(cfg_flen));
                frame_pos_now = rb.frame_end ? 8'd0 : 8'(next_pos);
                expected_bytes.push_back(rb);
            end
            // The score of the current phase leaks toward the limit of its sample's sign.
            sc = score_by_phase[line_phase];
            if (sample) begin
                sc += (int'(SCORE_LIMIT) - sc) / (1 << LEAK_SHIFT);
            end else begin
                sc -= (int'(SCORE_LIMIT) + sc) / (1 << LEAK_SHIFT);
            end
            score_by_phase[line_phase] = sc;
            line_phase = (line_phase + 1) % BIT_PHASES;
        end
        if (expected_bytes.size() > first_new) begin
            expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rx_byte want;
        if (!i_rst_n) begin
            expected_bytes.delete();
            foreach (score_by_phase[k]) score_by_phase[k] = 0;
            line_phase = 0;
            bit_window = '0;
            frame_pos_now = '0;
            cfg_sync = SYNC_RESET;
            cfg_hdr = HDR_RESET;
            cfg_flen = FLEN_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC_BYTE: begin
                        cfg_sync = i_cfg_data;
                    end
                    CFG_HEADER_LEN: begin
                        cfg_hdr = i_cfg_data[4:0];
                    end
                    CFG_FRAME_LEN: begin
                        cfg_flen = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (i_m_tuser[2]) o_frame_ends++;
                if (i_m_tuser[1]) o_inverted++;
                if (!i_m_tuser[0]) o_rejected++;
                if (expected_bytes.size() == 0) begin
                    $error("result with no byte expected: byte_value %0h, frame_pos %0h",
                           i_m_tdata[7:0], i_m_tdata[15:8]);
                    o_mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("byte_value", want.byte_value, i_m_tdata[7:0]);
                    check_field("frame_pos", want.frame_pos, i_m_tdata[15:8]);
                    check_field("accepted", 8'(want.accepted), 8'(i_m_tuser[0]));
                    check_field("inverted", 8'(want.inverted), 8'(i_m_tuser[1]));
                    check_field("frame_end", 8'(want.frame_end), 8'(i_m_tuser[2]));
                    check_field("last_of_run", 8'(want.last_of_run), 8'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                o_items++;
                recover_bytes(i_s_tdata);
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

[tb/async_byte_sync_deframer_test.sv]
// Testbench top for the byte synchronizer and deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module async_byte_sync_deframer_test;

    import absd_pkg::*;

    localparam int BIT_PHASES        = 10;
    localparam int SAMPLES_PER_INPUT = 4;
    localparam int SETTLE_CYCLES     = 100;
    localparam int HOLD_CYCLES       = 400;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [15:0]          o_m_tdata;
    logic                 o_m_tlast;
    logic [2:0]           o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    int n_mismatches;
    int n_pending;
    int n_items;
    int n_results;
    int n_frame_ends;
    int n_inverted;
    int n_rejected;

    int         sent_items = 0;
    int         s_idle_pct = 0;
    int         m_stall_pct = 0;
    logic       pressure_armed = 1'b0;
    logic       pressure_taken = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    bit         line_bits[$];
    logic [7:0] cur_sync = SYNC_RESET;
    logic [4:0] cur_hdr = HDR_RESET;
    logic [7:0] corner_bytes[10] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F,
                                     8'hFE, 8'hAA, 8'h55, 8'h2A, 8'hD5};

    always #10 i_clk = ~i_clk;

    async_byte_sync_deframer #(
        .BIT_PHASES        (BIT_PHASES),
        .SAMPLES_PER_INPUT (SAMPLES_PER_INPUT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    async_byte_sync_deframer_checker #(
        .BIT_PHASES        (BIT_PHASES),
        .SAMPLES_PER_INPUT (SAMPLES_PER_INPUT)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (n_mismatches),
        .o_pending    (n_pending),
        .o_items      (n_items),
        .o_results    (n_results),
        .o_frame_ends (n_frame_ends),
        .o_inverted   (n_inverted),
        .o_rejected   (n_rejected)
    );

    // The output side stalls at random, and once holds off long enough to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (pressure_armed && !pressure_taken) begin
            pressure_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without progress.", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_raw(input logic [7:0] raw);
        while ($urandom_range(99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= raw;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // Samples travel in bits 7, 5, 3 and 1; the even bits carry random filler.
    task automatic flush_line(input bit idle_level);
        logic [7:0] item;
        while (line_bits.size() % 4 != 0) line_bits.push_back(idle_level);
        while (line_bits.size() >= 4) begin
            item = 8'($urandom);
            item[7] = line_bits.pop_front();
            item[5] = line_bits.pop_front();
            item[3] = line_bits.pop_front();
            item[1] = line_bits.pop_front();
            send_raw(item);
        end
    endtask

    task automatic push_uart_byte(input logic [7:0] value, input bit flip);
        line_bits.push_back(flip);
        for (int i = 0; i < 8; i++) line_bits.push_back(value[i] ^ flip);
        line_bits.push_back(!flip);
    endtask

    // A frame starts with header_len sync bytes; a spoiled frame has one header bit flipped.
    task automatic send_frame(input int n_bytes, input bit flip, input bit spoil);
        logic [7:0] value;
        int         spoil_at;
        spoil_at = (cur_hdr > 0) ? $urandom_range(0, cur_hdr - 1) : 0;
        repeat ($urandom_range(0, 9)) line_bits.push_back(!flip);
        for (int i = 0; i < n_bytes; i++) begin
            value = (i < cur_hdr) ? cur_sync : 8'($urandom);
            if (spoil && i == spoil_at) value ^= 8'(1 << $urandom_range(7));
            push_uart_byte(value, flip);
        end
        flush_line(!flip);
    endtask

    task automatic run_random(input int n);
        int stop_at;
        int roll;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            roll = $urandom_range(9);
            if (roll < 7) begin
                send_frame(cur_hdr + $urandom_range(1, 12), ($urandom_range(3) == 0), 1'b0);
            end else if (roll == 7) begin
                send_frame(cur_hdr + $urandom_range(1, 6), 1'($urandom_range(1)), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) send_raw(8'($urandom));
            end
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] sync, input logic [7:0] hdr,
                             input logic [7:0] flen, input bit touch_spare);
        drain();
        if (touch_spare) write_reg(CFG_SPARE, 8'hFF);
        write_reg(CFG_SYNC_BYTE, sync);
        write_reg(CFG_HEADER_LEN, hdr);
        write_reg(CFG_FRAME_LEN, flen);
        i_cfg_valid <= 1'b0;
        cur_sync = sync;
        cur_hdr = hdr[4:0];
    endtask

    task automatic set_idling(input t_idle_mode mode);
        s_idle_pct = (mode == IDLE_SENDER) ? 80 : (mode == IDLE_BOTH) ? 38 : 0;
        m_stall_pct <= (mode == IDLE_RECEIVER) ? 80 : (mode == IDLE_BOTH) ? 38 : 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        foreach (corner_bytes[i]) send_raw(corner_bytes[i]);
        send_frame(6, 1'b0, 1'b0);

        configure(8'hFF, 8'd16, 8'd255, 1'b1);
        run_random(30);

        // Frame length drops below the position that the previous setting may have reached.
        configure(8'h00, 8'd0, 8'd17, 1'b0);
        set_idling(IDLE_SENDER);
        run_random(55);

        configure(8'hA5, 8'd3, 8'd20, 1'b0);
        set_idling(IDLE_RECEIVER);
        pressure_armed <= 1'b1;
        run_random(60);

        // Only the low five bits of the header length are kept.
        configure(8'h5A, 8'hE2, 8'd0, 1'b0);
        set_idling(IDLE_BOTH);
        run_random(35);

        configure(8'($urandom), 8'd1, 8'd1, 1'b0);
        set_idling(IDLE_NONE);
        run_random(30);

        configure(SYNC_RESET, 8'(HDR_RESET), FLEN_RESET, 1'b0);
        set_idling(IDLE_BOTH);
        run_random(55);

        drain();
        $display("Sent %0d items; got %0d bytes, %0d frame ends, %0d inverted, %0d rejected.",
                 n_items, n_results, n_frame_ends, n_inverted, n_rejected);
        $display("Six register settings, four idling modes and one long output hold-off.");
        if (n_mismatches == 0 && n_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/absd_pkg.sv
rtl/absd_ram.sv
rtl/absd_score_store.sv
rtl/absd_framer.sv
rtl/async_byte_sync_deframer.sv
tb/async_byte_sync_deframer_checker.sv
tb/async_byte_sync_deframer_test.sv
